### rtl/pfsd_pkg.sv
// Shared types and constants for the packet flood and scan detector.
// No dependencies; imported by the controller, datapath and top level.
package pfsd_pkg;

  localparam logic [15:0] IPV4_TYPE  = 16'h0800;
  localparam logic [7:0]  PROTO_TCP  = 8'd6;
  localparam logic [7:0]  PROTO_UDP  = 8'd17;
  localparam logic [7:0]  PROTO_ICMP = 8'd1;
  localparam int          FLAG_SYN_BIT = 1;
  localparam int          FLAG_ACK_BIT = 4;
  localparam logic [15:0] PORT_FTP    = 16'd21;
  localparam logic [15:0] PORT_TELNET = 16'd23;

  localparam logic [2:0] CLASS_NON_IPV4 = 3'd0;
  localparam logic [2:0] CLASS_TCP      = 3'd1;
  localparam logic [2:0] CLASS_UDP      = 3'd2;
  localparam logic [2:0] CLASS_ICMP     = 3'd3;
  localparam logic [2:0] CLASS_OTHER    = 3'd4;

  localparam logic [1:0] CFG_SYN_THR  = 2'd0;
  localparam logic [1:0] CFG_PORT_THR = 2'd1;
  localparam logic [1:0] CFG_ICMP_THR = 2'd2;
  localparam logic [1:0] CFG_STATS    = 2'd3;

  localparam logic [15:0] TALLY_MAX = 16'hFFFF;
  localparam logic [31:0] CNT_MAX   = 32'hFFFF_FFFF;

  typedef logic [15:0] svc_port_t [10];
  localparam svc_port_t SERVICE_PORTS = '{
    16'd80, 16'd443, 16'd53, 16'd21, 16'd22, 16'd23, 16'd25, 16'd110, 16'd143, 16'd8009
  };

  function automatic logic [3:0] service_of(input logic [15:0] port);
    logic [3:0] svc;
    svc = 4'd0;
    for (int i = 9; i >= 0; i--) begin
      if (SERVICE_PORTS[i] == port) svc = 4'(i + 1);
    end
    return svc;
  endfunction

  // controller -> datapath
  typedef struct packed {
    logic load;       // take input fields, bump counters
    logic clr_idx;    // restart source search
    logic rd_addr;    // read stored address at idx
    logic inc_idx;    // next entry
    logic take_hit;   // entry = idx
    logic alloc;      // new entry at fill
    logic mark_full;  // table full flag
    logic rd_entry;   // read tallies of entry
    logic upd_entry;  // update syn/icmp tally
    logic clr_k;      // restart port walk
    logic rd_port;    // read stored port k
    logic inc_k;      // next port
    logic port_new;   // port not in set: add if room
    logic port_old;   // port already in set
    logic finish;     // load result register
  } pfsd_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic tracked;
    logic is_tcp;
    logic idx_end;
    logic tbl_full;
    logic addr_hit;
    logic k_end;
    logic port_hit;
    logic res_free;
  } pfsd_stat_t;

endpackage

### rtl/pfsd_ctrl.sv
// Sequencing state machine of the detector.
// Depends on pfsd_pkg; drives the command struct of pfsd_datapath.
module pfsd_ctrl import pfsd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       pkt_valid,
  output logic       pkt_stall,
  input  pfsd_stat_t stat,
  output pfsd_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_CLASSIFY, S_LOOK, S_CMP, S_ENTRY, S_UPD, S_PSCAN, S_PCMP, S_FINISH
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  assign pkt_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (pkt_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CLASSIFY;
        end
      end
      S_CLASSIFY: begin
        if (stat.tracked) begin
          cmd.clr_idx = 1'b1;
          state_next  = S_LOOK;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_LOOK: begin
        if (stat.idx_end) begin
          if (stat.tbl_full) begin
            cmd.mark_full = 1'b1;
            state_next    = S_FINISH;
          end else begin
            cmd.alloc  = 1'b1;
            state_next = S_ENTRY;
          end
        end else begin
          cmd.rd_addr = 1'b1;
          state_next  = S_CMP;
        end
      end
      S_CMP: begin
        if (stat.addr_hit) begin
          cmd.take_hit = 1'b1;
          state_next   = S_ENTRY;
        end else begin
          cmd.inc_idx = 1'b1;
          state_next  = S_LOOK;
        end
      end
      S_ENTRY: begin
        cmd.rd_entry = 1'b1;
        state_next   = S_UPD;
      end
      S_UPD: begin
        cmd.upd_entry = 1'b1;
        if (stat.is_tcp) begin
          cmd.clr_k  = 1'b1;
          state_next = S_PSCAN;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_PSCAN: begin
        if (stat.k_end) begin
          cmd.port_new = 1'b1;
          state_next   = S_FINISH;
        end else begin
          cmd.rd_port = 1'b1;
          state_next  = S_PCMP;
        end
      end
      S_PCMP: begin
        if (stat.port_hit) begin
          cmd.port_old = 1'b1;
          state_next   = S_FINISH;
        end else begin
          cmd.inc_k  = 1'b1;
          state_next = S_PSCAN;
        end
      end
      S_FINISH: begin
        if (stat.res_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

### rtl/pfsd_datapath.sv
// Datapath: config registers, counters, source/port memories, result register.
// Depends on pfsd_pkg; commanded by pfsd_ctrl.
module pfsd_datapath import pfsd_pkg::*; #(
  parameter int SOURCES          = 64,
  parameter int PORTS_PER_SOURCE = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic [15:0] ether_type,
  input  logic [7:0]  ip_protocol,
  input  logic [31:0] src_address,
  input  logic [15:0] dest_port,
  input  logic [7:0]  tcp_flags,
  input  pfsd_cmd_t   cmd,
  output pfsd_stat_t  stat,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [2:0]  packet_class,
  output logic [3:0]  service_class,
  output logic        syn_flood_alert,
  output logic        port_scan_alert,
  output logic        cleartext_alert,
  output logic        icmp_flood_alert,
  output logic        table_full,
  output logic        stats_due,
  output logic [31:0] total_count,
  output logic [31:0] tcp_count,
  output logic [31:0] udp_count,
  output logic [31:0] icmp_count
);

  localparam int SW = (SOURCES > 1) ? $clog2(SOURCES) : 1;
  localparam int FW = $clog2(SOURCES + 1);
  localparam int KW = $clog2(PORTS_PER_SOURCE + 1);
  localparam int AW = $clog2(SOURCES * PORTS_PER_SOURCE);

  // config
  logic [15:0] syn_thr, icmp_thr, stats_int;
  logic [4:0]  port_thr;

  always_ff @(posedge clk) begin
    if (rst) begin
      syn_thr   <= 16'd100;
      port_thr  <= 5'd30;
      icmp_thr  <= 16'd100;
      stats_int <= 16'd100;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SYN_THR:  syn_thr   <= cfg_data;
        CFG_PORT_THR: port_thr  <= cfg_data[4:0];
        CFG_ICMP_THR: icmp_thr  <= cfg_data;
        CFG_STATS:    stats_int <= cfg_data;
        default: ;
      endcase
    end
  end

  // packet working registers
  logic [2:0]  pclass;
  logic [3:0]  svc;
  logic [31:0] addr_q;
  logic [15:0] port_q;
  logic        syn_cond, clear_al, syn_al, scan_al, icmp_al, full_fl;
  logic [31:0] total_seen, tcp_seen, udp_seen, icmp_seen;
  logic [15:0] interval_cnt;

  logic [2:0] pclass_next;
  always_comb begin
    pclass_next = CLASS_NON_IPV4;
    if (ether_type == IPV4_TYPE) begin
      case (ip_protocol)
        PROTO_TCP:  pclass_next = CLASS_TCP;
        PROTO_UDP:  pclass_next = CLASS_UDP;
        PROTO_ICMP: pclass_next = CLASS_ICMP;
        default:    pclass_next = CLASS_OTHER;
      endcase
    end
  end

  // source table, filled from entry 0 upwards and never freed
  logic [FW-1:0] fill, idx;
  logic [SW-1:0] entry;
  logic [31:0]   addr_mem [SOURCES];
  logic [15:0]   syn_mem  [SOURCES];
  logic [15:0]   icmp_mem [SOURCES];
  logic [KW-1:0] ptal_mem [SOURCES];
  logic [15:0]   port_mem [SOURCES * PORTS_PER_SOURCE];
  logic [31:0]   addr_rd;
  logic [15:0]   syn_rd, icmp_rd, port_rd;
  logic [KW-1:0] ptal_rd, k;
  logic [AW-1:0] pbase;

  logic [15:0]   syn_new, icmp_new;
  logic [KW-1:0] ptal_new;
  assign syn_new  = (syn_rd == TALLY_MAX) ? syn_rd : syn_rd + 16'd1;
  assign icmp_new = (icmp_rd == TALLY_MAX) ? icmp_rd : icmp_rd + 16'd1;
  assign ptal_new = (ptal_rd < KW'(PORTS_PER_SOURCE)) ? ptal_rd + KW'(1) : ptal_rd;

  always_ff @(posedge clk) begin
    if (cmd.rd_addr) addr_rd <= addr_mem[idx[SW-1:0]];
    if (cmd.alloc)   addr_mem[fill[SW-1:0]] <= addr_q;
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_entry) begin
      syn_rd  <= syn_mem[entry];
      icmp_rd <= icmp_mem[entry];
      ptal_rd <= ptal_mem[entry];
      pbase   <= AW'(32'(entry) * PORTS_PER_SOURCE);
    end
    if (cmd.alloc) begin
      syn_mem[fill[SW-1:0]]  <= '0;
      icmp_mem[fill[SW-1:0]] <= '0;
    end else if (cmd.upd_entry) begin
      if (pclass == CLASS_TCP && syn_cond) syn_mem[entry] <= syn_new;
      if (pclass == CLASS_ICMP)            icmp_mem[entry] <= icmp_new;
    end
    if (cmd.alloc) ptal_mem[fill[SW-1:0]] <= '0;
    else if (cmd.port_new) ptal_mem[entry] <= ptal_new;
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_port) port_rd <= port_mem[pbase + AW'(k)];
    if (cmd.port_new && ptal_rd < KW'(PORTS_PER_SOURCE))
      port_mem[pbase + AW'(ptal_rd)] <= port_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (cmd.alloc) begin
      fill <= fill + FW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_idx) idx <= '0;
    else if (cmd.inc_idx) idx <= idx + FW'(1);
    if (cmd.take_hit) entry <= idx[SW-1:0];
    else if (cmd.alloc) entry <= fill[SW-1:0];
    if (cmd.clr_k) k <= '0;
    else if (cmd.inc_k) k <= k + KW'(1);
  end

  // per-packet flags and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      total_seen <= '0;
      tcp_seen   <= '0;
      udp_seen   <= '0;
      icmp_seen  <= '0;
    end else if (cmd.load) begin
      if (total_seen != CNT_MAX) total_seen <= total_seen + 32'd1;
      if (pclass_next == CLASS_TCP && tcp_seen != CNT_MAX) tcp_seen <= tcp_seen + 32'd1;
      if (pclass_next == CLASS_UDP && udp_seen != CNT_MAX) udp_seen <= udp_seen + 32'd1;
      if (pclass_next == CLASS_ICMP && icmp_seen != CNT_MAX)
        icmp_seen <= icmp_seen + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pclass   <= pclass_next;
      addr_q   <= src_address;
      port_q   <= dest_port;
      syn_cond <= tcp_flags[FLAG_SYN_BIT] & ~tcp_flags[FLAG_ACK_BIT];
      svc      <= (pclass_next == CLASS_TCP || pclass_next == CLASS_UDP) ?
                  service_of(dest_port) : 4'd0;
      clear_al <= (pclass_next == CLASS_TCP) &&
                  (dest_port == PORT_FTP || dest_port == PORT_TELNET);
      syn_al   <= 1'b0;
      scan_al  <= 1'b0;
      icmp_al  <= 1'b0;
      full_fl  <= 1'b0;
    end else begin
      if (cmd.mark_full) full_fl <= 1'b1;
      if (cmd.upd_entry) begin
        if (pclass == CLASS_TCP && syn_cond) syn_al <= (syn_new > syn_thr);
        if (pclass == CLASS_ICMP) icmp_al <= (icmp_new > icmp_thr);
      end
      if (cmd.port_new) scan_al <= (32'(ptal_new) > 32'(port_thr));
      if (cmd.port_old) scan_al <= (32'(ptal_rd) > 32'(port_thr));
    end
  end

  // stats interval, evaluated when the result is posted
  logic [16:0] int_nx, int_lim;
  logic        due;
  assign int_nx  = 17'(interval_cnt) + 17'd1;
  assign int_lim = (stats_int == 16'd0) ? 17'd1 : 17'(stats_int);
  assign due     = (int_nx >= int_lim);

  always_ff @(posedge clk) begin
    if (rst) begin
      interval_cnt <= '0;
      res_valid    <= 1'b0;
    end else begin
      if (cmd.finish) begin
        interval_cnt <= due ? 16'd0 : int_nx[15:0];
        res_valid    <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      packet_class     <= pclass;
      service_class    <= svc;
      syn_flood_alert  <= syn_al;
      port_scan_alert  <= scan_al;
      cleartext_alert  <= clear_al;
      icmp_flood_alert <= icmp_al;
      table_full       <= full_fl;
      stats_due        <= due;
      total_count      <= total_seen;
      tcp_count        <= tcp_seen;
      udp_count        <= udp_seen;
      icmp_count       <= icmp_seen;
    end
  end

  always_comb begin
    stat.tracked  = (pclass == CLASS_TCP) || (pclass == CLASS_ICMP);
    stat.is_tcp   = (pclass == CLASS_TCP);
    stat.idx_end  = (idx == fill);
    stat.tbl_full = (fill == FW'(SOURCES));
    stat.addr_hit = (addr_rd == addr_q);
    stat.k_end    = (k == ptal_rd);
    stat.port_hit = (port_rd == port_q);
    stat.res_free = !(res_valid && res_stall);
  end

endmodule

### rtl/packet_flood_scan_detector_unit.sv
// Top level of the packet flood and scan detector.
// Depends on pfsd_pkg, pfsd_ctrl and pfsd_datapath.

// Takes one parsed header summary per transfer and returns one result
// transfer: class, service, alert flags, table-full flag, stats flag and
// saturating protocol counters. TCP and ICMP sources are tracked in a
// table of SOURCES entries filled from the bottom and never freed, so a
// fill count stands in for per-entry valid bits; no clearing pass is needed
// after reset. One packet is handled at a time. Non-IPv4, UDP and other
// IPv4 packets go straight to the result. For ICMP and TCP the address
// memory is walked until the source is found; if it is not, a new entry is
// allocated, or, when the table is full, the table-full flag is set and the
// packet goes to the result with no tally update. Otherwise the entry's
// tallies are read and updated; for TCP the stored ports of the entry are
// then walked until a match, and a new port is added if there is room.
// The address memory and port memory are single-port, each walked one
// entry at a time (read, then compare). The controller returns to idle as
// the result register is loaded, so the next input transfer can be taken
// while that result shows valid. A finished result sits in an output
// register, so the next packet is taken while it waits; the following
// result waits until that register frees. Configuration writes are always
// taken.
module packet_flood_scan_detector_unit import pfsd_pkg::*; #(
  parameter int SOURCES          = 64,
  parameter int PORTS_PER_SOURCE = 32
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // header summary in
  input  logic        pkt_valid,
  output logic        pkt_stall,
  input  logic [15:0] ether_type,
  input  logic [7:0]  ip_protocol,
  input  logic [31:0] src_address,
  input  logic [15:0] dest_port,
  input  logic [7:0]  tcp_flags,
  // result out
  output logic        res_valid,
  input  logic        res_stall,
  output logic [2:0]  packet_class,
  output logic [3:0]  service_class,
  output logic        syn_flood_alert,
  output logic        port_scan_alert,
  output logic        cleartext_alert,
  output logic        icmp_flood_alert,
  output logic        table_full,
  output logic        stats_due,
  output logic [31:0] total_count,
  output logic [31:0] tcp_count,
  output logic [31:0] udp_count,
  output logic [31:0] icmp_count
);

  pfsd_cmd_t  cmd;
  pfsd_stat_t stat;

  // user must change registers only between packets; writes never held off
  assign cfg_ready = 1'b1;

  pfsd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .pkt_valid (pkt_valid),
    .pkt_stall (pkt_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  pfsd_datapath #(
    .SOURCES          (SOURCES),
    .PORTS_PER_SOURCE (PORTS_PER_SOURCE)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .ether_type       (ether_type),
    .ip_protocol      (ip_protocol),
    .src_address      (src_address),
    .dest_port        (dest_port),
    .tcp_flags        (tcp_flags),
    .cmd              (cmd),
    .stat             (stat),
    .res_valid        (res_valid),
    .res_stall        (res_stall),
    .packet_class     (packet_class),
    .service_class    (service_class),
    .syn_flood_alert  (syn_flood_alert),
    .port_scan_alert  (port_scan_alert),
    .cleartext_alert  (cleartext_alert),
    .icmp_flood_alert (icmp_flood_alert),
    .table_full       (table_full),
    .stats_due        (stats_due),
    .total_count      (total_count),
    .tcp_count        (tcp_count),
    .udp_count        (udp_count),
    .icmp_count       (icmp_count)
  );

endmodule
